// ----- rtl/dfs_pkg.sv -----
// Shared types and constants of the directional focus search unit.
// Holds the request structs, the front-to-back queue entry and the codes.
// Depends on nothing.
package dfs_pkg;

	localparam int COORD_BITS      = 16;
	localparam int ID_BITS         = 16;
	localparam int DEF_QUEUE_DEPTH = 4;

	// seeded best rectangle edges
	localparam int EXT_BITS    = COORD_BITS + 2;
	// edge differences between source and target
	localparam int DIFF_BITS   = COORD_BITS + 3;
	localparam int MAJOR_BITS  = COORD_BITS + 2;
	localparam int MINOR_BITS  = COORD_BITS;
	localparam int WEIGHT_BITS = 2 * MAJOR_BITS + 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EXT_BITS-1:0]   ext_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic [MAJOR_BITS-1:0]        major_t;
	typedef logic [MINOR_BITS-1:0]        minor_t;
	typedef logic [WEIGHT_BITS-1:0]       weight_t;
	typedef logic [ID_BITS-1:0]           id_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_CAND  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef struct packed {
		cmd_t   command;
		dir_t   direction;
		coord_t rect_left;
		coord_t rect_top;
		coord_t rect_right;
		coord_t rect_bottom;
		id_t    item_id;
		logic   last;
	} in_item_t;

	typedef struct packed {
		logic found;
		id_t  best_id;
	} out_item_t;

	typedef struct packed {
		logic   is_start;
		logic   last;
		logic   horiz;
		id_t    id;
		logic   is_cand;
		logic   in_beam;
		logic   toward;
		major_t major;
		major_t far;
		minor_t minor;
	} q_entry_t;

endpackage

// ----- rtl/directional_focus_search_unit.sv -----
// Directional focus search unit: top level joining front, queue and back.
// Uses dfs_pkg, dfs_front, dfs_queue and dfs_back.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------
//   item     | item_valid / item_stall     | in_item_t  (start or candidate)
//   result   | result_valid / result_stall | out_item_t (found, best_id)
//
// One request per cycle sustained while item_stall stays low; the held best is updated in back stage s4.
// A result is registered once its last request has passed front stages s1 and s2, the queue and back stages s3 and s4.
// Reset clears the source to zero, direction to left and the best to none.
// A stalled result holds the back part first; the queue keeps the front moving until it is full.
module directional_focus_search_unit import dfs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic     f_valid, f_stall;
	q_entry_t f_entry;
	logic     b_valid, b_stall;
	q_entry_t b_entry;

	dfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.ent_valid  (f_valid),
		.ent_stall  (f_stall),
		.ent        (f_entry)
	);

	dfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_stall (f_stall),
		.push_entry (f_entry),
		.pop_valid  (b_valid),
		.pop_stall  (b_stall),
		.pop_entry  (b_entry)
	);

	dfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ent_valid    (b_valid),
		.ent_stall    (b_stall),
		.ent          (b_entry),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- rtl/dfs_front.sv -----
// Front part: accepts requests, builds the seed rectangle for a start and
// measures each target against the held source. Uses dfs_pkg.
module dfs_front import dfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  in_item_t item,
	output logic     ent_valid,
	input  logic     ent_stall,
	output q_entry_t ent
);

	function automatic coord_t centre(coord_t lo, coord_t hi);
		logic signed [COORD_BITS:0] span;
		logic signed [COORD_BITS:0] half;
		logic signed [COORD_BITS:0] mid;
		span = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
		half = $signed(span + {{COORD_BITS{1'b0}}, span[COORD_BITS]}) >>> 1;
		mid  = {lo[COORD_BITS-1], lo} + half;
		return mid[COORD_BITS-1:0];
	endfunction

	function automatic ext_t to_ext(coord_t v);
		return {{(EXT_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
	endfunction

	function automatic diff_t to_diff(ext_t v);
		return {{(DIFF_BITS-EXT_BITS){v[EXT_BITS-1]}}, v};
	endfunction

	logic     v_s1, v_s2;
	in_item_t item_s1;
	logic     s1_adv, s2_free;

	logic   start_s2, last_s2;
	id_t    id_s2;
	ext_t   tl_s2, tt_s2, tr_s2, tb_s2;
	coord_t cv_s2, ch_s2;

	coord_t src_l_q, src_t_q, src_r_q, src_b_q;
	coord_t src_cv_q, src_ch_q;
	dir_t   dir_q;

	ext_t   l1, t1, r1, b1, w1, h1;
	ext_t   tl1, tt1, tr1, tb1;
	coord_t cv1, ch1;
	logic   start1;

	assign s2_free    = !v_s2 || !ent_stall;
	assign s1_adv     = v_s1 && s2_free;
	assign item_stall = v_s1 && !s2_free;
	assign start1     = (item_s1.command == CMD_START);

	always_comb begin
		l1  = to_ext(item_s1.rect_left);
		t1  = to_ext(item_s1.rect_top);
		r1  = to_ext(item_s1.rect_right);
		b1  = to_ext(item_s1.rect_bottom);
		w1  = r1 - l1 + ext_t'(1);
		h1  = b1 - t1 + ext_t'(1);
		tl1 = l1;
		tt1 = t1;
		tr1 = r1;
		tb1 = b1;
		if (start1) begin
			case (item_s1.direction)
				DIR_LEFT: begin
					tl1 = l1 + w1;
					tr1 = r1 + w1;
				end
				DIR_RIGHT: begin
					tl1 = l1 - w1;
					tr1 = r1 - w1;
				end
				DIR_UP: begin
					tt1 = t1 + h1;
					tb1 = b1 + h1;
				end
				DIR_DOWN: begin
					tt1 = t1 - h1;
					tb1 = b1 - h1;
				end
				default: begin
					tl1 = l1;
				end
			endcase
		end
		cv1 = centre(item_s1.rect_top, item_s1.rect_bottom);
		ch1 = centre(item_s1.rect_left, item_s1.rect_right);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			src_l_q  <= '0;
			src_t_q  <= '0;
			src_r_q  <= '0;
			src_b_q  <= '0;
			src_cv_q <= '0;
			src_ch_q <= '0;
			dir_q    <= DIR_LEFT;
		end else begin
			if (!item_stall) begin
				v_s1 <= item_valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (s1_adv && start1) begin
				src_l_q  <= item_s1.rect_left;
				src_t_q  <= item_s1.rect_top;
				src_r_q  <= item_s1.rect_right;
				src_b_q  <= item_s1.rect_bottom;
				src_cv_q <= cv1;
				src_ch_q <= ch1;
				dir_q    <= item_s1.direction;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (s1_adv) begin
			start_s2 <= start1;
			last_s2  <= item_s1.last;
			id_s2    <= item_s1.item_id;
			tl_s2    <= tl1;
			tt_s2    <= tt1;
			tr_s2    <= tr1;
			tb_s2    <= tb1;
			cv_s2    <= cv1;
			ch_s2    <= ch1;
		end
	end

	diff_t sl, st, sr, sb, dl, dt, dr, db;
	diff_t mj_raw, far_raw;
	logic  cand2, toward2, beam2, horiz2;
	logic signed [COORD_BITS:0] md, mmag;
	coord_t ca, cb;

	always_comb begin
		sl = to_diff(to_ext(src_l_q));
		st = to_diff(to_ext(src_t_q));
		sr = to_diff(to_ext(src_r_q));
		sb = to_diff(to_ext(src_b_q));
		dl = to_diff(tl_s2);
		dt = to_diff(tt_s2);
		dr = to_diff(tr_s2);
		db = to_diff(tb_s2);
		cand2   = 1'b0;
		toward2 = 1'b0;
		mj_raw  = '0;
		far_raw = '0;
		case (dir_q)
			DIR_LEFT: begin
				cand2   = (sr > dr || sl >= dr) && sl > dl;
				toward2 = sl >= dr;
				mj_raw  = sl - dr;
				far_raw = sl - dl;
			end
			DIR_RIGHT: begin
				cand2   = (sl < dl || sr <= dl) && sr < dr;
				toward2 = sr <= dl;
				mj_raw  = dl - sr;
				far_raw = dr - sr;
			end
			DIR_UP: begin
				cand2   = (sb > db || st >= db) && st > dt;
				toward2 = st >= db;
				mj_raw  = st - db;
				far_raw = st - dt;
			end
			DIR_DOWN: begin
				cand2   = (st < dt || sb <= dt) && sb < db;
				toward2 = sb <= dt;
				mj_raw  = dt - sb;
				far_raw = db - sb;
			end
			default: begin
				cand2 = 1'b0;
			end
		endcase
		horiz2 = (dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT);
		beam2  = horiz2 ? (db >= st && dt <= sb) : (dr >= sl && dl <= sr);
		ca     = horiz2 ? src_cv_q : src_ch_q;
		cb     = horiz2 ? cv_s2 : ch_s2;
		md     = {ca[COORD_BITS-1], ca} - {cb[COORD_BITS-1], cb};
		mmag   = md[COORD_BITS] ? -md : md;

		ent.is_start = start_s2;
		ent.last     = last_s2;
		ent.horiz    = horiz2;
		ent.id       = id_s2;
		ent.is_cand  = cand2;
		ent.in_beam  = beam2;
		ent.toward   = toward2;
		ent.major    = mj_raw[DIFF_BITS-1] ? '0 : mj_raw[MAJOR_BITS-1:0];
		ent.far      = (far_raw < diff_t'(1)) ? major_t'(1) : far_raw[MAJOR_BITS-1:0];
		ent.minor    = mmag[MINOR_BITS-1:0];
	end

	assign ent_valid = v_s2;

endmodule

// ----- rtl/dfs_queue.sv -----
// Short queue of measured requests between the front and back parts.
// Register array with read and write pointers. Uses dfs_pkg.
module dfs_queue import dfs_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_stall,
	input  q_entry_t push_entry,
	output logic     pop_valid,
	input  logic     pop_stall,
	output q_entry_t pop_entry
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	function automatic logic [PTR_BITS-1:0] next_ptr(logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	q_entry_t mem [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic push, pop;

	assign push_stall = (count_q == CNT_BITS'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/dfs_back.sv -----
// Back part: squares the distances, forms 13*major^2 + minor^2, judges each
// target against the held best and drives the result register. Uses dfs_pkg.
module dfs_back import dfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ent_valid,
	output logic      ent_stall,
	input  q_entry_t  ent,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	typedef struct packed {
		logic    cand;
		logic    in_beam;
		logic    toward;
		major_t  major;
		major_t  far;
		weight_t weight;
	} metric_t;

	logic     v_s3, v_s4;
	q_entry_t ent_s3, ent_s4;
	logic [2*MAJOR_BITS-1:0] sq_major_s3;
	logic [2*MINOR_BITS-1:0] sq_minor_s3;
	weight_t  weight_s4;

	metric_t  best_q, nxt_best, cur;
	id_t      best_id_q, nxt_id;
	logic     have_best_q, nxt_have;

	logic      result_valid_q;
	out_item_t result_q;

	logic out_free, s4_adv, s4_free, s3_adv, s3_free;
	logic take, c_beats_b, b_beats_c;

	assign out_free  = !result_valid_q || !result_stall;
	assign s4_adv    = v_s4 && (!ent_s4.last || out_free);
	assign s4_free   = !v_s4 || s4_adv;
	assign s3_adv    = v_s3 && s4_free;
	assign s3_free   = !v_s3 || s3_adv;
	assign ent_stall = !s3_free;

	always_comb begin
		cur.cand    = ent_s4.is_cand;
		cur.in_beam = ent_s4.in_beam;
		cur.toward  = ent_s4.toward;
		cur.major   = ent_s4.major;
		cur.far     = ent_s4.far;
		cur.weight  = weight_s4;

		c_beats_b = !best_q.in_beam && cur.in_beam &&
			(!best_q.toward || ent_s4.horiz || cur.major < best_q.far);
		b_beats_c = !cur.in_beam && best_q.in_beam &&
			(!cur.toward || ent_s4.horiz || best_q.major < cur.far);

		if (!cur.cand) begin
			take = 1'b0;
		end else if (!best_q.cand) begin
			take = 1'b1;
		end else if (c_beats_b) begin
			take = 1'b1;
		end else if (b_beats_c) begin
			take = 1'b0;
		end else begin
			take = cur.weight < best_q.weight;
		end

		nxt_best = best_q;
		nxt_id   = best_id_q;
		nxt_have = have_best_q;
		if (ent_s4.is_start) begin
			nxt_best = cur;
			nxt_id   = '0;
			nxt_have = 1'b0;
		end else if (take) begin
			nxt_best = cur;
			nxt_id   = ent_s4.id;
			nxt_have = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
			best_q.cand    <= 1'b0;
			best_q.in_beam <= 1'b1;
			best_q.toward  <= 1'b1;
			best_q.major   <= '0;
			best_q.far     <= major_t'(1);
			best_q.weight  <= '0;
			best_id_q      <= '0;
			have_best_q    <= 1'b0;
		end else begin
			if (s3_free) begin
				v_s3 <= ent_valid;
			end
			if (s4_free) begin
				v_s4 <= v_s3;
			end
			if (s4_adv) begin
				best_q      <= nxt_best;
				best_id_q   <= nxt_id;
				have_best_q <= nxt_have;
			end
			if (s4_adv && ent_s4.last) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_valid && s3_free) begin
			ent_s3      <= ent;
			sq_major_s3 <= {{MAJOR_BITS{1'b0}}, ent.major} * {{MAJOR_BITS{1'b0}}, ent.major};
			sq_minor_s3 <= {{MINOR_BITS{1'b0}}, ent.minor} * {{MINOR_BITS{1'b0}}, ent.minor};
		end
		if (s3_adv) begin
			ent_s4    <= ent_s3;
			weight_s4 <= (weight_t'(sq_major_s3) << 3) + (weight_t'(sq_major_s3) << 2)
				+ weight_t'(sq_major_s3) + weight_t'(sq_minor_s3);
		end
		if (s4_adv && ent_s4.last) begin
			result_q.found   <= nxt_have;
			result_q.best_id <= nxt_have ? nxt_id : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_best_is_cand: assert property (@(posedge clk) disable iff (!arst_n)
		have_best_q |-> best_q.cand)
		else $error("taken best is not a candidate");

	a_none_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.found |-> result_q.best_id == '0)
		else $error("nonzero id without a find");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s4_adv && ent_s4.last |=> result_valid_q)
		else $error("last request gave no result");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ent_stall |-> v_s3 && v_s4)
		else $error("back stalls while a stage is empty");

endmodule

// ----- verif/directional_focus_search_unit_tb.sv -----
// Self-checking testbench for directional_focus_search_unit: directed and random
// searches in all four directions, checked against a predictor kept alongside.
// Depends on dfs_pkg and the RTL of directional_focus_search_unit.
`timescale 1ns / 100ps

module directional_focus_search_unit_tb import dfs_pkg::*;;

	localparam int IDLE_LIMIT   = 5000;
	localparam int REQUEST_GOAL = 600;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		longint l;
		longint t;
		longint r;
		longint b;
	} box_t;

	logic      clk;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	in_item_t  pending_requests[$];
	out_item_t expected_results[$];

	box_t src_box;
	box_t best_box;
	dir_t search_dir;
	id_t  held_id;
	bit   held_valid;

	int fail_count   = 0;
	int accepted_cnt = 0;
	int idle_cycles  = 0;
	int burst_left   = 0;
	int gap_left     = 0;
	int hold_left    = 0;
	int hold_count   = 0;
	int seg_left     = 0;
	int stall_pct    = 0;

	directional_focus_search_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit is_horizontal(dir_t dir);
		return dir == DIR_LEFT || dir == DIR_RIGHT;
	endfunction

	function automatic bit ahead_of(box_t s, box_t d, dir_t dir);
		case (dir)
			DIR_LEFT:  return (s.r > d.r || s.l >= d.r) && s.l > d.l;
			DIR_RIGHT: return (s.l < d.l || s.r <= d.l) && s.r < d.r;
			DIR_UP:    return (s.b > d.b || s.t >= d.b) && s.t > d.t;
			default:   return (s.t < d.t || s.b <= d.t) && s.b < d.b;
		endcase
	endfunction

	function automatic bit overlaps_beam(box_t s, box_t d, dir_t dir);
		if (is_horizontal(dir))
			return d.b >= s.t && d.t <= s.b;
		return d.r >= s.l && d.l <= s.r;
	endfunction

	function automatic bit fully_beyond(box_t s, box_t d, dir_t dir);
		case (dir)
			DIR_LEFT:  return s.l >= d.r;
			DIR_RIGHT: return s.r <= d.l;
			DIR_UP:    return s.t >= d.b;
			default:   return s.b <= d.t;
		endcase
	endfunction

	function automatic longint near_gap(box_t s, box_t d, dir_t dir);
		longint v;
		case (dir)
			DIR_LEFT:  v = s.l - d.r;
			DIR_RIGHT: v = d.l - s.r;
			DIR_UP:    v = s.t - d.b;
			default:   v = d.t - s.b;
		endcase
		return (v < 0) ? 0 : v;
	endfunction

	function automatic longint far_gap(box_t s, box_t d, dir_t dir);
		longint v;
		case (dir)
			DIR_LEFT:  v = s.l - d.l;
			DIR_RIGHT: v = d.r - s.r;
			DIR_UP:    v = s.t - d.t;
			default:   v = d.b - s.b;
		endcase
		return (v < 1) ? 1 : v;
	endfunction

	function automatic longint cross_gap(box_t s, box_t d, dir_t dir);
		longint a;
		longint c;
		longint v;
		if (is_horizontal(dir)) begin
			a = s.t + (s.b - s.t) / 2;
			c = d.t + (d.b - d.t) / 2;
		end else begin
			a = s.l + (s.r - s.l) / 2;
			c = d.l + (d.r - d.l) / 2;
		end
		v = a - c;
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit beam_favours(box_t s, box_t r1, box_t r2, dir_t dir);
		if (overlaps_beam(s, r2, dir) || !overlaps_beam(s, r1, dir))
			return 1'b0;
		if (!fully_beyond(s, r2, dir))
			return 1'b1;
		if (is_horizontal(dir))
			return 1'b1;
		return near_gap(s, r1, dir) < far_gap(s, r2, dir);
	endfunction

	function automatic longint weighted_gap(box_t s, box_t d, dir_t dir);
		longint mj;
		longint mn;
		mj = near_gap(s, d, dir);
		mn = cross_gap(s, d, dir);
		return 13 * mj * mj + mn * mn;
	endfunction

	function automatic bit outranks(box_t s, box_t c, box_t b, dir_t dir);
		if (!ahead_of(s, c, dir))
			return 1'b0;
		if (!ahead_of(s, b, dir))
			return 1'b1;
		if (beam_favours(s, c, b, dir))
			return 1'b1;
		if (beam_favours(s, b, c, dir))
			return 1'b0;
		return weighted_gap(s, c, dir) < weighted_gap(s, b, dir);
	endfunction

	function automatic void apply_request(input in_item_t req, output bit emits,
			output out_item_t res);
		box_t   box;
		longint w;
		longint h;
		box.l = $signed(req.rect_left);
		box.t = $signed(req.rect_top);
		box.r = $signed(req.rect_right);
		box.b = $signed(req.rect_bottom);
		if (req.command == CMD_START) begin
			w = box.r - box.l + 1;
			h = box.b - box.t + 1;
			src_box  = box;
			best_box = box;
			case (req.direction)
				DIR_LEFT: begin
					best_box.l += w;
					best_box.r += w;
				end
				DIR_RIGHT: begin
					best_box.l -= w;
					best_box.r -= w;
				end
				DIR_UP: begin
					best_box.t += h;
					best_box.b += h;
				end
				default: begin
					best_box.t -= h;
					best_box.b -= h;
				end
			endcase
			search_dir = req.direction;
			held_id    = '0;
			held_valid = 1'b0;
		end else if (outranks(src_box, box, best_box, search_dir)) begin
			best_box   = box;
			held_id    = req.item_id;
			held_valid = 1'b1;
		end
		emits       = req.last;
		res.found   = held_valid;
		res.best_id = held_valid ? held_id : '0;
	endfunction

	task automatic push_req(cmd_t cmd, dir_t dir, int l, int t, int r, int b, int id,
			bit last);
		in_item_t req;
		req.command     = cmd;
		req.direction   = dir;
		req.rect_left   = coord_t'(l);
		req.rect_top    = coord_t'(t);
		req.rect_right  = coord_t'(r);
		req.rect_bottom = coord_t'(b);
		req.item_id     = id_t'(id);
		req.last        = last;
		pending_requests.push_back(req);
	endtask

	function automatic in_item_t random_rect(in_item_t req);
		int mode;
		int cx;
		int cy;
		int w;
		int h;
		mode = $urandom_range(0, 11);
		if (mode == 0) begin
			req.rect_left   = coord_t'($urandom);
			req.rect_top    = coord_t'($urandom);
			req.rect_right  = coord_t'($urandom);
			req.rect_bottom = coord_t'($urandom);
		end else begin
			cx = int'($urandom_range(0, 600)) - 300;
			cy = int'($urandom_range(0, 600)) - 300;
			w  = $urandom_range(0, 80);
			h  = $urandom_range(0, 80);
			if (mode == 1)
				w = -w;
			if (mode == 2)
				h = -h;
			req.rect_left   = coord_t'(cx);
			req.rect_top    = coord_t'(cy);
			req.rect_right  = coord_t'(cx + w);
			req.rect_bottom = coord_t'(cy + h);
		end
		return req;
	endfunction

	task automatic build_random_searches();
		in_item_t req;
		in_item_t prev;
		int       kind;
		int       n;
		int       count;
		prev = '0;
		count = 0;
		while (count < REQUEST_GOAL) begin
			kind = $urandom_range(0, 19);
			req = '0;
			req.direction = dir_t'($urandom_range(0, 3));
			req.item_id   = id_t'($urandom_range(0, 65535));
			if (kind == 0) begin
				req.command = CMD_CAND;
				req.last    = 1'($urandom_range(0, 1));
				pending_requests.push_back(random_rect(req));
				count++;
			end else if (kind == 1) begin
				req.command = CMD_START;
				req.last    = 1'b1;
				pending_requests.push_back(random_rect(req));
				count++;
			end else begin
				req.command = CMD_START;
				req.last    = 1'b0;
				pending_requests.push_back(random_rect(req));
				count++;
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) begin
					req = '0;
					req.command   = CMD_CAND;
					req.direction = dir_t'($urandom_range(0, 3));
					req.item_id   = id_t'($urandom_range(0, 65535));
					req.last      = (i == n - 1) && kind != 2;
					if (i > 0 && $urandom_range(0, 5) == 0) begin
						req.rect_left   = prev.rect_left;
						req.rect_top    = prev.rect_top;
						req.rect_right  = prev.rect_right;
						req.rect_bottom = prev.rect_bottom;
					end else begin
						req = random_rect(req);
					end
					prev = req;
					pending_requests.push_back(req);
					count++;
				end
			end
		end
	endtask

	initial begin
		src_box    = '0;
		best_box   = '0;
		search_dir = DIR_LEFT;
		held_id    = '0;
		held_valid = 1'b0;

		push_req(CMD_CAND, DIR_UP, -10, -5, -3, 5, 'h7, 1'b1);
		push_req(CMD_START, DIR_RIGHT, 0, 0, 10, 10, 0, 1'b1);
		push_req(CMD_START, DIR_LEFT, 100, 100, 120, 120, 0, 1'b0);
		push_req(CMD_CAND, DIR_DOWN, 50, 300, 70, 320, 'h11, 1'b0);
		push_req(CMD_CAND, DIR_LEFT, 10, 105, 30, 115, 'h12, 1'b0);
		push_req(CMD_CAND, DIR_RIGHT, 10, 105, 30, 115, 'h13, 1'b0);
		push_req(CMD_CAND, DIR_UP, 130, 100, 150, 120, 'h14, 1'b1);
		push_req(CMD_START, DIR_UP, 0, 0, 20, 20, 0, 1'b0);
		push_req(CMD_CAND, DIR_LEFT, 40, -30, 60, -10, 'h21, 1'b0);
		push_req(CMD_CAND, DIR_UP, 5, -100, 15, -80, 'h22, 1'b1);
		push_req(CMD_START, DIR_DOWN, -32768, -32768, 32767, 32767, 0, 1'b0);
		push_req(CMD_CAND, DIR_DOWN, 32767, 32767, 32767, 32767, 'hffff, 1'b1);
		push_req(CMD_START, DIR_DOWN, -20, -20, -10, -10, 0, 1'b0);
		push_req(CMD_CAND, DIR_RIGHT, 10, 40, -10, 20, 'hffff, 1'b0);
		push_req(CMD_CAND, DIR_DOWN, -15, 0, -12, 5, 0, 1'b1);
		push_req(CMD_START, DIR_RIGHT, -32768, 0, -32700, 10, 0, 1'b0);
		push_req(CMD_CAND, DIR_LEFT, 32000, 0, 32767, 10, 'h8000, 1'b0);
		push_req(CMD_CAND, DIR_UP, -32768, -32768, -32768, -32768, 'h1, 1'b1);
		build_random_searches();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (fail_count == 0)
			$display("directional_focus_search_unit_tb: PASS");
		else
			$display("directional_focus_search_unit_tb: FAIL");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : drive_requests
		out_item_t res;
		bit        emits;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				apply_request(item, emits, res);
				if (emits)
					expected_results.push_back(res);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left   <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					item       <= pending_requests.pop_front();
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// hold off for a long stretch twice so that the input side backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (hold_count < 2 && accepted_cnt >= 120 + 250 * hold_count) begin
			hold_count   <= hold_count + 1;
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (seg_left == 0) begin
			seg_left     <= $urandom_range(16, 96);
			stall_pct    <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 70);
			result_stall <= 1'b0;
		end else begin
			seg_left     <= seg_left - 1;
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: found=%0d best_id=%h",
						result.found, result.best_id);
			end else begin
				want = expected_results.pop_front();
				if (want.found !== result.found || want.best_id !== result.best_id) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: want found=%0d best_id=%h, got found=%0d best_id=%h",
							want.found, want.best_id, result.found, result.best_id);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("directional_focus_search_unit_tb: FAIL");
				$finish;
			end
		end
	end

endmodule
